>>> rtl/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, masked while reset is high.
`define ASSERT_CLK(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked check that also holds across reset.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> rtl/fdd_pkg.sv
// Types and constants for the finite-difference derivative block.
`default_nettype none

package fdd_pkg;

   localparam int SAMPLE_BITS  = 32;
   localparam int FIELD_BITS   = 32;
   localparam int CSR_BITS     = 32;
   localparam int SPACING_FRAC = 16;
   localparam int RESULT_BITS  = 32;

   localparam logic [CSR_BITS-1:0] CSR_RESET = 32'h0001_0000;

   localparam logic [1:0] KIND_FORWARD  = 2'd0;
   localparam logic [1:0] KIND_CENTRAL  = 2'd1;
   localparam logic [1:0] KIND_BACKWARD = 2'd2;

   typedef struct packed {
      logic signed [FIELD_BITS-1:0] sample_value;
      logic                         last_sample;
   } req_type;

   typedef struct packed {
      logic signed [RESULT_BITS-1:0] derivative;
      logic [1:0]                    stencil_kind;
      logic                          end_of_run;
      logic                          too_short;
      logic                          clipped;
   } rsp_type;

   // Sideband that rides along with a weighted difference through the scaler
   typedef struct packed {
      logic [1:0] stencil_kind;
      logic       end_of_run;
      logic       too_short;
   } tag_type;

endpackage

`default_nettype wire

>>> rtl/fdd_tap.sv
// One cell of the sample window: holds a sample and hands it to the next cell.
`default_nettype none

module fdd_tap #(
   parameter int WIDTH = fdd_pkg::SAMPLE_BITS
) (
   input  wire logic                    clock,
   input  wire logic                    shift,
   input  wire logic signed [WIDTH-1:0] d,
   output logic signed [WIDTH-1:0]      q
);

   logic signed [WIDTH-1:0] sample_ff;

   always_ff @(posedge clock) begin
      if (shift) begin
         sample_ff <= d;
      end
   end

   assign q = sample_ff;

endmodule

`default_nettype wire

>>> rtl/fdd_scale.sv
// Scaler: magnitude, split multiply by 1/(2dx), rounding and saturation.
`default_nettype none

module fdd_scale #(
   parameter int DIFF_BITS = fdd_pkg::SAMPLE_BITS + 3
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic [fdd_pkg::CSR_BITS-1:0]        csr_value,
   input  wire logic                                in_valid,
   output logic                                     in_ready,
   input  wire logic signed [DIFF_BITS-1:0]         in_diff,
   input  wire fdd_pkg::tag_type                    in_tag,
   output logic                                     out_valid,
   input  wire logic                                out_ready,
   output fdd_pkg::rsp_type                         out_data
);

   localparam int CB       = fdd_pkg::CSR_BITS;
   localparam int SF       = fdd_pkg::SPACING_FRAC;
   localparam int RB       = fdd_pkg::RESULT_BITS;
   localparam int MAG_BITS = (DIFF_BITS > CB + 1) ? DIFF_BITS : CB + 1;
   localparam int HI_BITS  = MAG_BITS - CB;
   localparam int Q_BITS   = CB + SF + 1;

   logic v1_ff, v2_ff, v3_ff, v4_ff;
   logic rdy1, rdy2, rdy3, rdy4;

   logic signed [DIFF_BITS-1:0]  diff_ff;
   fdd_pkg::tag_type             tag1_ff, tag2_ff, tag3_ff;
   logic                         neg2_ff, neg3_ff;
   logic [MAG_BITS-1:0]          mag_ff;
   logic [2*CB-1:0]              plo_ff;
   logic [HI_BITS+CB-1:0]        phi_ff;
   fdd_pkg::rsp_type             out_ff;

   logic signed [MAG_BITS-1:0]   diff_ext;
   logic [MAG_BITS-1:0]          mag_in;
   logic                         big;
   logic [Q_BITS-1:0]            q_sum;
   logic [Q_BITS-1:0]            limit;
   logic                         clip;
   logic [RB-1:0]                q_sat;
   fdd_pkg::rsp_type             out_in;

   assign rdy4     = !v4_ff || out_ready;
   assign rdy3     = !v3_ff || rdy4;
   assign rdy2     = !v2_ff || rdy3;
   assign rdy1     = !v1_ff || rdy2;
   assign in_ready = rdy1;

   always_comb begin
      diff_ext = MAG_BITS'(diff_ff);
      mag_in   = diff_ff[DIFF_BITS-1] ? MAG_BITS'(0) - diff_ext : diff_ext;
   end

   // Round half up on the magnitude, then clamp to the signed result range
   always_comb begin
      big   = |phi_ff[HI_BITS+CB-1:CB];
      q_sum = {1'b0, phi_ff[CB-1:0], {SF{1'b0}}}
            + Q_BITS'(plo_ff >> SF)
            + Q_BITS'(plo_ff[SF-1]);
      limit = neg3_ff ? (Q_BITS'(1) << (RB - 1)) : (Q_BITS'(1) << (RB - 1)) - Q_BITS'(1);
      clip  = big || (q_sum > limit);
      q_sat = clip ? limit[RB-1:0] : q_sum[RB-1:0];
      out_in.derivative   = neg3_ff ? RB'(0) - q_sat : q_sat;
      out_in.stencil_kind = tag3_ff.stencil_kind;
      out_in.end_of_run   = tag3_ff.end_of_run;
      out_in.too_short    = tag3_ff.too_short;
      out_in.clipped      = clip;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else begin
         if (rdy1) v1_ff <= in_valid;
         if (rdy2) v2_ff <= v1_ff;
         if (rdy3) v3_ff <= v2_ff;
         if (rdy4) v4_ff <= v3_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (rdy1) begin
         diff_ff <= in_diff;
         tag1_ff <= in_tag;
      end
      if (rdy2) begin
         mag_ff  <= mag_in;
         neg2_ff <= diff_ff[DIFF_BITS-1];
         tag2_ff <= tag1_ff;
      end
      if (rdy3) begin
         plo_ff  <= mag_ff[CB-1:0] * csr_value;
         phi_ff  <= mag_ff[MAG_BITS-1:CB] * csr_value;
         neg3_ff <= neg2_ff;
         tag3_ff <= tag2_ff;
      end
      if (rdy4) begin
         out_ff <= out_in;
      end
   end

   assign out_valid = v4_ff;
   assign out_data  = out_ff;

endmodule

`default_nettype wire

>>> rtl/finite_difference_derivative.sv
// Each released job is registered in pending_ff, then passes diff_ff, mag_ff, the partial
// products and out_ff; extra results follow in issue order: forward, central, backward.
// Throughput: one request and one result per cycle in steady state unless stalled; each
// result passes one slot of a four-stage scaler pipeline (two partial products per item).
// The third request of a run and the last of a run of four or more release one extra
// result each, a run of three releases two, and req_ready stays low while extras wait.
// Reset clears the run count, pending work and pipeline; half_inverse_spacing = 1.0.
`default_nettype none

module finite_difference_derivative #(
   parameter int SAMPLE_BITS = fdd_pkg::SAMPLE_BITS
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_ready,
   input  wire fdd_pkg::req_type              req_data,
   output logic                               rsp_valid,
   input  wire logic                          rsp_ready,
   output fdd_pkg::rsp_type                   rsp_data,
   input  wire logic                          csr_valid,
   output logic                               csr_ready,
   input  wire logic [fdd_pkg::CSR_BITS-1:0]  csr_data
);

   localparam int FB        = fdd_pkg::FIELD_BITS;
   localparam int DIFF_BITS = SAMPLE_BITS + 3;
   localparam int TAPS      = 3;

   typedef struct packed {
      logic fwd;
      logic cen;
      logic bwd;
      logic short_run;
   } jobs_type;

   logic [fdd_pkg::CSR_BITS-1:0] csr_ff, csr_in;
   logic [1:0]                   count_ff, count_in;
   jobs_type                     pending_ff, pending_in;
   jobs_type                     new_jobs, sel, pend_after;

   logic                          accept;
   logic [SAMPLE_BITS-1:0]        raw;
   logic signed [SAMPLE_BITS-1:0] tap_d [TAPS];
   logic signed [SAMPLE_BITS-1:0] tap_q [TAPS];
   logic signed [DIFF_BITS-1:0]   e0, e1, e2;
   logic signed [DIFF_BITS-1:0]   job_diff;
   fdd_pkg::tag_type              job_tag;
   logic                          issue, scale_ready;

   assign csr_ready = 1'b1;
   assign accept    = req_valid && req_ready;

   generate
      if (SAMPLE_BITS <= FB) begin : g_narrow
         assign raw = req_data.sample_value[SAMPLE_BITS-1:0];
      end else begin : g_wide
         assign raw = {{(SAMPLE_BITS-FB){1'b0}}, req_data.sample_value};
      end
   endgenerate

   // Window cells, newest in cell 0
   assign tap_d[0] = raw;
   genvar k;
   generate
      for (k = 0; k < TAPS; k++) begin : g_tap
         if (k > 0) begin : g_link
            assign tap_d[k] = tap_q[k-1];
         end
         fdd_tap #(.WIDTH(SAMPLE_BITS)) u_tap (
            .clock (clock),
            .shift (accept),
            .d     (tap_d[k]),
            .q     (tap_q[k])
         );
      end
   endgenerate

   assign e2 = DIFF_BITS'(tap_q[0]);
   assign e1 = DIFF_BITS'(tap_q[1]);
   assign e0 = DIFF_BITS'(tap_q[2]);

   // Jobs released by the request being accepted
   always_comb begin
      new_jobs = '0;
      if (count_ff < 2'd2) begin
         new_jobs.short_run = req_data.last_sample;
      end else begin
         new_jobs.fwd = (count_ff == 2'd2);
         new_jobs.cen = 1'b1;
         new_jobs.bwd = req_data.last_sample;
      end
   end

   always_comb begin
      sel      = '0;
      job_diff = '0;
      job_tag  = '0;
      priority if (pending_ff.fwd) begin
         sel.fwd              = 1'b1;
         job_diff             = (e1 <<< 2) - (e0 <<< 1) - e0 - e2;
         job_tag.stencil_kind = fdd_pkg::KIND_FORWARD;
      end else if (pending_ff.cen) begin
         sel.cen              = 1'b1;
         job_diff             = e2 - e0;
         job_tag.stencil_kind = fdd_pkg::KIND_CENTRAL;
      end else if (pending_ff.bwd) begin
         sel.bwd              = 1'b1;
         job_diff             = (e2 <<< 1) + e2 - (e1 <<< 2) + e0;
         job_tag.stencil_kind = fdd_pkg::KIND_BACKWARD;
         job_tag.end_of_run   = 1'b1;
      end else begin
         // short run; with nothing pending the job is not issued
         sel.short_run        = 1'b1;
         job_tag.stencil_kind = fdd_pkg::KIND_BACKWARD;
         job_tag.end_of_run   = 1'b1;
         job_tag.too_short    = 1'b1;
      end
   end

   assign issue      = (pending_ff != '0) && scale_ready;
   assign pend_after = issue ? (pending_ff & ~sel) : pending_ff;
   // Window may shift only when no job stays pending past this cycle's issue
   assign req_ready  = (pend_after == '0);

   always_comb begin
      pending_in = accept ? new_jobs : pend_after;
      count_in   = count_ff;
      if (accept) begin
         if (req_data.last_sample) begin
            count_in = 2'd0;
         end else if (count_ff < 2'd3) begin
            count_in = count_ff + 2'd1;
         end
      end
      csr_in = (csr_valid && csr_ready) ? csr_data : csr_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         csr_ff     <= fdd_pkg::CSR_RESET;
         count_ff   <= 2'd0;
         pending_ff <= '0;
      end else begin
         csr_ff     <= csr_in;
         count_ff   <= count_in;
         pending_ff <= pending_in;
      end
   end

   fdd_scale #(.DIFF_BITS(DIFF_BITS)) u_scale (
      .clock     (clock),
      .reset     (reset),
      .csr_value (csr_ff),
      .in_valid  (issue),
      .in_ready  (scale_ready),
      .in_diff   (job_diff),
      .in_tag    (job_tag),
      .out_valid (rsp_valid),
      .out_ready (rsp_ready),
      .out_data  (rsp_data)
   );

endmodule

`default_nettype wire

>>> rtl/fdd_checker.sv
// Port-level checks for the finite-difference derivative block, bound to the top.
`default_nettype none
`include "assert_macros.svh"

module fdd_checker (
   input wire logic             clock,
   input wire logic             reset,
   input wire logic             rsp_valid,
   input wire logic             rsp_ready,
   input wire fdd_pkg::rsp_type rsp_data
);

   `ASSERT_ALWAYS(a_reset_clears_rsp, clock, reset |=> !rsp_valid, "rsp_valid after reset")

   `ASSERT_CLK(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data), "rsp changed while stalled")

   `ASSERT_CLK(a_end_is_backward, clock, reset, rsp_valid |-> (rsp_data.end_of_run == (rsp_data.stencil_kind == fdd_pkg::KIND_BACKWARD)), "end_of_run and stencil disagree")

   `ASSERT_CLK(a_short_run, clock, reset, rsp_valid && rsp_data.too_short |-> rsp_data.end_of_run && rsp_data.derivative == '0 && !rsp_data.clipped, "bad short-run result")

   `ASSERT_CLK(a_clip_at_rail, clock, reset, rsp_valid && rsp_data.clipped |-> rsp_data.derivative == 32'sh7fff_ffff || rsp_data.derivative == 32'sh8000_0000, "clipped value not at a rail")

endmodule

bind finite_difference_derivative fdd_checker u_fdd_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);

`default_nettype wire

>>> tb/finite_difference_derivative_tb.sv
// Self-checking testbench for the finite-difference derivative block.
module finite_difference_derivative_tb;
   import fdd_pkg::*;

   localparam int          DRAIN_CYCLES = 12;
   localparam int          STALL_CYCLES = 300;
   localparam logic [31:0] SAMPLE_MAX   = 32'h7fff_ffff;
   localparam logic [31:0] SAMPLE_MIN   = 32'h8000_0000;
   localparam logic [31:0] SPACING_MAX  = 32'hffff_ffff;
   localparam logic [31:0] SPACING_HALF = 32'h0000_8000;

   logic                clock     = 1'b0;
   logic                reset     = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_ready;
   req_type             req_data  = '0;
   logic                rsp_valid;
   logic                rsp_ready = 1'b0;
   rsp_type             rsp_data;
   logic                csr_valid = 1'b0;
   logic                csr_ready;
   logic [CSR_BITS-1:0] csr_data  = '0;

   // Predictor state
   logic signed [63:0] window [3] = '{64'sd0, 64'sd0, 64'sd0};
   logic [1:0]         run_count  = 2'd0;
   logic [31:0]        spacing    = CSR_RESET;
   rsp_type            pending_derivs [$];

   int send_idle_pct  = 0;
   int recv_idle_pct  = 0;
   int hold_len       = 0;
   int hold_cnt       = 0;
   int mismatch_count = 0;

   finite_difference_derivative dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   initial begin
      #2_000_000;
      $display("Simulation FAILED");
      $finish;
   end

   // |diff| * spacing, rounded half away from zero, then saturated
   function automatic rsp_type scale_difference(logic signed [63:0] diff, logic [1:0] kind,
                                                logic eor);
      logic        neg;
      logic        clip;
      logic [63:0] mag;
      logic [63:0] plo;
      logic [63:0] phi;
      logic [63:0] lim;
      logic [63:0] lo_sh;
      logic [63:0] q;
      rsp_type     r;
      neg  = diff < 0;
      mag  = neg ? 64'd0 - diff : diff;
      plo  = {32'd0, mag[31:0]} * {32'd0, spacing};
      phi  = {32'd0, mag[63:32]} * {32'd0, spacing};
      lim  = neg ? 64'h8000_0000 : 64'h7fff_ffff;
      clip = 1'b0;
      q    = '0;
      if (phi >= 64'h1_0000_0000) begin
         clip = 1'b1;
      end else begin
         lo_sh = (plo >> SPACING_FRAC)
               + (((plo & 64'hffff) + 64'h8000) >> SPACING_FRAC);
         q = (phi << (32 - SPACING_FRAC)) + lo_sh;
         if (q > lim) clip = 1'b1;
      end
      if (clip) q = lim;
      if (neg) q = 64'd0 - q;
      r.derivative   = q[31:0];
      r.stencil_kind = kind;
      r.end_of_run   = eor;
      r.too_short    = 1'b0;
      r.clipped      = clip;
      return r;
   endfunction

   function automatic void predict_derivatives(logic signed [31:0] value, logic is_last);
      logic signed [63:0] s;
      logic [1:0]         c;
      rsp_type            r;
      s = value;
      c = run_count;
      window[0] = window[1];
      window[1] = window[2];
      window[2] = s;
      if (c < 2) begin
         if (!is_last) begin
            run_count = c + 2'd1;
            return;
         end
         r.derivative   = '0;
         r.stencil_kind = KIND_BACKWARD;
         r.end_of_run   = 1'b1;
         r.too_short    = 1'b1;
         r.clipped      = 1'b0;
         pending_derivs.push_back(r);
      end else begin
         if (c == 2)
            pending_derivs.push_back(scale_difference(
               -3 * window[0] + 4 * window[1] - window[2], KIND_FORWARD, 1'b0));
         pending_derivs.push_back(scale_difference(window[2] - window[0], KIND_CENTRAL, 1'b0));
         if (is_last)
            pending_derivs.push_back(scale_difference(
               3 * window[2] - 4 * window[1] + window[0], KIND_BACKWARD, 1'b1));
      end
      if (is_last) begin
         run_count = 2'd0;
         window    = '{64'sd0, 64'sd0, 64'sd0};
      end else begin
         run_count = 2'd3;
      end
   endfunction

   function automatic void check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
      if (exp_v !== act_v) begin
         mismatch_count++;
         if (mismatch_count <= 10)
            $display("mismatch %s: expected %h, got %h", name, exp_v, act_v);
      end
   endfunction

   // Result side: check accepted results, then pick next ready
   always @(posedge clock) begin
      rsp_type exp_r;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_derivs.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("unexpected result: derivative %h kind %0d",
                        rsp_data.derivative, rsp_data.stencil_kind);
         end else begin
            exp_r = pending_derivs.pop_front();
            check_field("derivative", exp_r.derivative, rsp_data.derivative);
            check_field("stencil_kind", exp_r.stencil_kind, rsp_data.stencil_kind);
            check_field("end_of_run", exp_r.end_of_run, rsp_data.end_of_run);
            check_field("too_short", exp_r.too_short, rsp_data.too_short);
            check_field("clipped", exp_r.clipped, rsp_data.clipped);
         end
      end
      if (hold_len != 0 && hold_cnt < hold_len) begin
         hold_cnt  <= hold_cnt + 1;
         rsp_ready <= 1'b0;
      end else begin
         if (hold_len == 0) hold_cnt <= 0;
         rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   task automatic send_sample(logic signed [31:0] value, logic is_last);
      // each cycle before a request is idle with the sender's idle percentage
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= {value, is_last};
      do @(posedge clock); while (!req_ready);
      predict_derivatives(value, is_last);
   endtask

   task automatic stop_sending();
      req_valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic wait_drain();
      while (pending_derivs.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // Register writes only happen with the block empty and between runs
   task automatic program_spacing(logic [31:0] value);
      stop_sending();
      wait_drain();
      csr_valid <= 1'b1;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      spacing = value;
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic set_idling(int send_pct, int recv_pct);
      send_idle_pct <= send_pct;
      recv_idle_pct <= recv_pct;
      @(posedge clock);
   endtask

   function automatic logic [31:0] pick_sample();
      case ($urandom_range(9))
         0:       return SAMPLE_MAX;
         1:       return SAMPLE_MIN;
         2:       return 32'd0;
         3, 4, 5: return int'($urandom_range(0, 2000)) - 1000;
         default: return $urandom;
      endcase
   endfunction

   function automatic logic [31:0] pick_spacing();
      case ($urandom_range(5))
         0:       return 32'd0;
         1:       return SPACING_MAX;
         2:       return CSR_RESET;
         3:       return 32'd1;
         default: return $urandom;
      endcase
   endfunction

   function automatic int pick_run_length();
      case ($urandom_range(9))
         0:       return 1;
         1:       return 2;
         2:       return 3;
         default: return $urandom_range(4, 12);
      endcase
   endfunction

   // Sends one whole run; returns the number of requests
   task automatic send_run(int len, output int sent);
      logic signed [31:0] base;
      logic signed [31:0] step;
      logic               smooth;
      smooth = ($urandom_range(3) != 0);
      base   = int'($urandom_range(0, 200000)) - 100000;
      step   = int'($urandom_range(0, 4000)) - 2000;
      for (int i = 0; i < len; i++) begin
         if (smooth) send_sample(base + i * step + int'($urandom_range(0, 64)), i == len - 1);
         else        send_sample(pick_sample(), i == len - 1);
      end
      sent = len;
   endtask

   task automatic test_short_runs();
      send_sample(32'sd1234, 1'b1);
      send_sample(SAMPLE_MAX, 1'b0);
      send_sample(SAMPLE_MIN, 1'b1);
   endtask

   task automatic test_three_sample_run();
      send_sample(32'sd0, 1'b0);
      send_sample(32'sh0001_0000, 1'b0);
      send_sample(32'sh0004_0000, 1'b1);
   endtask

   task automatic test_saturation();
      program_spacing(SPACING_MAX);
      send_sample(SAMPLE_MAX, 1'b0);
      send_sample(SAMPLE_MIN, 1'b0);
      send_sample(SAMPLE_MAX, 1'b0);
      send_sample(SAMPLE_MIN, 1'b0);
      send_sample(SAMPLE_MAX, 1'b1);
   endtask

   // odd differences at one half land on .5 in both signs
   task automatic test_rounding();
      program_spacing(SPACING_HALF);
      send_sample(32'sd0, 1'b0);
      send_sample(32'sd1, 1'b0);
      send_sample(-32'sd1, 1'b0);
      send_sample(32'sd0, 1'b1);
   endtask

   task automatic test_zero_spacing();
      program_spacing(32'd0);
      send_sample(SAMPLE_MAX, 1'b0);
      send_sample(SAMPLE_MIN, 1'b0);
      send_sample(32'sd7, 1'b1);
   endtask

   task automatic test_random_runs(int target);
      int total;
      int chunk;
      int n;
      total = 0;
      while (total < target) begin
         program_spacing(pick_spacing());
         chunk = 0;
         while (chunk < 30) begin
            send_run(pick_run_length(), n);
            chunk += n;
         end
         total += chunk;
      end
   endtask

   task automatic test_stall_fill();
      int n;
      int sent;
      program_spacing(CSR_RESET);
      hold_len <= STALL_CYCLES;
      sent = 0;
      while (sent < 40) begin
         send_run(pick_run_length(), n);
         sent += n;
      end
      while (hold_cnt < STALL_CYCLES) @(posedge clock);
      hold_len <= 0;
      @(posedge clock);
   endtask

   task automatic test_drain_pause();
      int n;
      send_run(6, n);
      stop_sending();
      while (pending_derivs.size() != 0) @(posedge clock);
      send_run(5, n);
   endtask

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      set_idling(7, 60);
      test_short_runs();
      test_three_sample_run();
      test_saturation();
      test_rounding();
      test_zero_spacing();
      test_random_runs(90);
      test_stall_fill();

      set_idling(60, 7);
      test_random_runs(90);
      test_drain_pause();

      set_idling(0, 0);
      test_random_runs(90);

      stop_sending();
      wait_drain();
      if (mismatch_count == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

endmodule

>>> sim.f
+incdir+rtl
rtl/fdd_pkg.sv
rtl/fdd_tap.sv
rtl/fdd_scale.sv
rtl/finite_difference_derivative.sv
rtl/fdd_checker.sv
tb/finite_difference_derivative_tb.sv
